>>> rtl/mnar_pkg.sv
`default_nettype none

package mnar_pkg;

  localparam int NOTE_COUNT    = 128;
  localparam int CHANNEL_COUNT = 16;
  localparam int NOTE_W        = 7;
  localparam int CHAN_W        = 4;
  localparam int VEL_W         = 7;
  localparam int COUNT_W       = 8;
  localparam int PANIC_RESULTS = 2 * CHANNEL_COUNT;
  localparam int PANIC_W       = 5;
  localparam int PERC_CHANNEL  = 9;
  localparam int QUEUE_DEPTH   = 4;

  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 56;
  localparam int ADDR_W     = 4;
  localparam int APB_W      = 32;

  // function codes carried in the low bits of s_tuser
  typedef enum logic [1:0] {
    FUNC_PLAY     = 2'd0,
    FUNC_THRU     = 2'd1,
    FUNC_ACTIVITY = 2'd2,
    FUNC_PANIC    = 2'd3
  } func_t;

  // thru modes
  localparam logic [2:0] THRU_OFF     = 3'd0;
  localparam logic [2:0] THRU_ALL     = 3'd1;
  localparam logic [2:0] THRU_HW_USB  = 3'd2;
  localparam logic [2:0] THRU_USB_HW  = 3'd3;
  localparam logic [2:0] THRU_HW_HW   = 3'd4;
  localparam logic [2:0] THRU_USB_USB = 3'd5;

  // register indexes
  localparam logic [1:0] REG_OUT_TARGET = 2'd0;
  localparam logic [1:0] REG_THRU_MODE  = 2'd1;
  localparam logic [1:0] REG_AUDIO_OUT  = 2'd2;

  // status high nibbles
  localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
  localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
  localparam logic [3:0] TYPE_CC       = 4'hB;
  localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
  localparam logic [3:0] TYPE_PRESSURE = 4'hD;
  localparam logic [3:0] TYPE_SYSTEM   = 4'hF;

  localparam logic [6:0] CC_SOUND_OFF = 7'd120;
  localparam logic [6:0] CC_NOTES_OFF = 7'd123;

  localparam logic [1:0] COUNT_ONE = 2'd1;
  localparam logic [1:0] COUNT_TWO = 2'd2;

  // classified item handed from front to back
  typedef struct packed {
    logic              panic;
    logic              upd;
    logic              upd_set;
    logic [CHAN_W-1:0] chan;
    logic [NOTE_W-1:0] note;
    logic [VEL_W-1:0]  vel;
    logic [NOTE_W-1:0] query;
    logic              send_hw;
    logic              send_usb;
    logic              to_synth;
    logic [7:0]        status;
    logic [6:0]        first;
    logic [6:0]        second;
    logic [1:0]        count;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/mnar_ram.sv
`default_nettype none

module mnar_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> rtl/mnar_front.sv
`default_nettype none

module mnar_front (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // apb
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [mnar_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [mnar_pkg::APB_W-1:0]       pwdata,
  output logic      [mnar_pkg::APB_W-1:0]       prdata,
  // input stream
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [mnar_pkg::IN_DATA_W-1:0]   s_tdata,
  input  wire logic [mnar_pkg::IN_USER_W-1:0]   s_tuser,
  // queue side
  input  wire logic                             q_full,
  output logic                                  q_push,
  output mnar_pkg::cmd_t                        q_data
);

  logic [1:0] out_target;
  logic [2:0] thru_mode;
  logic       audio_out;

  logic                           cfg_wr;
  mnar_pkg::func_t                func;
  logic                           from_hw;
  logic [7:0]                     status;
  logic [6:0]                     data1;
  logic [6:0]                     data2;
  logic [6:0]                     query;
  logic [3:0]                     typ;
  logic                           voice;

  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_target <= 2'd3;
      thru_mode  <= mnar_pkg::THRU_OFF;
      audio_out  <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        mnar_pkg::REG_OUT_TARGET: out_target <= pwdata[1:0];
        mnar_pkg::REG_THRU_MODE:  thru_mode  <= pwdata[2:0];
        mnar_pkg::REG_AUDIO_OUT:  audio_out  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      mnar_pkg::REG_OUT_TARGET: prdata = {30'd0, out_target};
      mnar_pkg::REG_THRU_MODE:  prdata = {29'd0, thru_mode};
      mnar_pkg::REG_AUDIO_OUT:  prdata = {31'd0, audio_out};
      default:                  prdata = '0;
    endcase
  end

  assign func    = mnar_pkg::func_t'(s_tuser[1:0]);
  assign from_hw = s_tuser[2];
  assign status  = s_tdata[7:0];
  assign data1   = s_tdata[14:8];
  assign data2   = s_tdata[21:15];
  assign query   = s_tdata[28:22];
  assign typ     = status[7:4];
  assign voice   = status[7] && (typ != mnar_pkg::TYPE_SYSTEM);

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_data       = '0;
    q_data.chan  = status[3:0];
    q_data.note  = data1;
    q_data.vel   = data2;
    q_data.query = query;
    case (func)
      mnar_pkg::FUNC_PANIC: begin
        q_data.panic    = 1'b1;
        q_data.send_hw  = out_target[0];
        q_data.send_usb = out_target[1];
      end
      mnar_pkg::FUNC_ACTIVITY: begin
        q_data.upd     = 1'b1;
        q_data.upd_set = (data2 != 7'd0);
      end
      default: begin
        if (voice) begin
          q_data.status = status;
          q_data.first  = data1;
          if (typ inside {mnar_pkg::TYPE_PROGRAM, mnar_pkg::TYPE_PRESSURE}) begin
            q_data.count = mnar_pkg::COUNT_ONE;
          end else begin
            q_data.count  = mnar_pkg::COUNT_TWO;
            q_data.second = data2;
          end
          if (func == mnar_pkg::FUNC_PLAY) begin
            q_data.send_hw  = out_target[0];
            q_data.send_usb = out_target[1];
            if (typ == mnar_pkg::TYPE_NOTE_OFF) begin
              q_data.upd = 1'b1;
            end else if (typ == mnar_pkg::TYPE_NOTE_ON) begin
              q_data.upd     = 1'b1;
              q_data.upd_set = (data2 != 7'd0);
            end
            if (typ inside {mnar_pkg::TYPE_NOTE_OFF, mnar_pkg::TYPE_NOTE_ON,
                            mnar_pkg::TYPE_PROGRAM}) begin
              q_data.to_synth = audio_out;
            end
          end else begin
            case (thru_mode)
              mnar_pkg::THRU_ALL: begin
                q_data.send_hw  = 1'b1;
                q_data.send_usb = 1'b1;
              end
              mnar_pkg::THRU_HW_USB:  q_data.send_usb = from_hw;
              mnar_pkg::THRU_USB_HW:  q_data.send_hw  = !from_hw;
              mnar_pkg::THRU_HW_HW:   q_data.send_hw  = from_hw;
              mnar_pkg::THRU_USB_USB: q_data.send_usb = !from_hw;
              default: ;
            endcase
          end
        end
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/mnar_queue.sv
`default_nettype none

module mnar_queue #(
  parameter int DEPTH = mnar_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire mnar_pkg::cmd_t push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                empty,
  output mnar_pkg::cmd_t      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mnar_pkg::cmd_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full  = (fill == CNT_W'(DEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> rtl/mnar_back.sv
`default_nettype none

module mnar_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              q_empty,
  input  wire mnar_pkg::cmd_t                    q_head,
  output logic                                   q_pop,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic      [mnar_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                                   m_tlast
);

  localparam int NC = mnar_pkg::NOTE_COUNT;
  localparam int CC = mnar_pkg::CHANNEL_COUNT;
  localparam int NW = mnar_pkg::NOTE_W;
  localparam int VW = mnar_pkg::VEL_W;
  localparam int KW = mnar_pkg::COUNT_W;
  localparam int PW = mnar_pkg::PANIC_W;

  typedef enum logic [1:0] {ST_FETCH, ST_EXEC, ST_PANIC} state_t;

  state_t         state;
  mnar_pkg::cmd_t cmd;
  logic [PW-1:0]  panic_idx;
  logic [NC-1:0]  held_valid;
  logic [NC-1:0]  vel_valid;
  logic [KW-1:0]  chan_count [CC];
  logic [KW-1:0]  chan_count_next [CC];

  logic [NW-1:0]  rd_note;
  logic [NW-1:0]  rd_query;
  logic [CC-1:0]  held_a_rdata;
  logic [CC-1:0]  held_b_rdata;
  logic [VW-1:0]  vel_rdata;

  logic [CC-1:0]  held_note;
  logic [CC-1:0]  held_query;
  logic [VW-1:0]  vel_query;
  logic [CC-1:0]  chan_bit;
  logic           bit_was;
  logic [CC-1:0]  held_new;
  logic           hit;
  logic [CC-1:0]  held_rep;
  logic [VW-1:0]  vel_rep;
  logic [CC-1:0]  active_mask;
  logic           out_free;
  logic           out_load;
  logic           held_we;
  logic           vel_we;
  logic           panic_last;

  // ram addresses come straight from the queue head while fetching
  assign rd_note  = (state == ST_FETCH) ? q_head.note  : cmd.note;
  assign rd_query = (state == ST_FETCH) ? q_head.query : cmd.query;

  mnar_ram #(.WIDTH(CC), .DEPTH(NC)) u_held_a (
    .clk     (clk),
    .wr_en   (held_we),
    .wr_addr (cmd.note),
    .wr_data (held_new),
    .rd_addr (rd_note),
    .rd_data (held_a_rdata)
  );

  mnar_ram #(.WIDTH(CC), .DEPTH(NC)) u_held_b (
    .clk     (clk),
    .wr_en   (held_we),
    .wr_addr (cmd.note),
    .wr_data (held_new),
    .rd_addr (rd_query),
    .rd_data (held_b_rdata)
  );

  mnar_ram #(.WIDTH(VW), .DEPTH(NC)) u_vel (
    .clk     (clk),
    .wr_en   (vel_we),
    .wr_addr (cmd.note),
    .wr_data (cmd.vel),
    .rd_addr (rd_query),
    .rd_data (vel_rdata)
  );

  assign held_note  = held_valid[cmd.note]  ? held_a_rdata : '0;
  assign held_query = held_valid[cmd.query] ? held_b_rdata : '0;
  assign vel_query  = vel_valid[cmd.query]  ? vel_rdata    : '0;

  always_comb begin
    chan_bit           = '0;
    chan_bit[cmd.chan] = 1'b1;
  end

  assign bit_was  = |(held_note & chan_bit);
  assign held_new = cmd.upd_set ? (held_note | chan_bit) : (held_note & ~chan_bit);

  // report the query note as it stands after this update
  assign hit      = cmd.upd && (cmd.query == cmd.note);
  assign held_rep = hit ? held_new : held_query;
  assign vel_rep  = (hit && cmd.upd_set) ? cmd.vel : vel_query;

  always_comb begin
    for (int c = 0; c < CC; c++) begin
      chan_count_next[c] = chan_count[c];
    end
    if (cmd.upd) begin
      if (cmd.upd_set && !bit_was) begin
        chan_count_next[cmd.chan] = chan_count[cmd.chan] + 1'b1;
      end else if (!cmd.upd_set && bit_was) begin
        chan_count_next[cmd.chan] = chan_count[cmd.chan] - 1'b1;
      end
    end
    for (int c = 0; c < CC; c++) begin
      active_mask[c] = (chan_count_next[c] != '0);
    end
  end

  assign out_free   = !m_tvalid || m_tready;
  assign out_load   = out_free && ((state == ST_EXEC) || (state == ST_PANIC));
  assign held_we    = (state == ST_EXEC) && out_free && cmd.upd;
  assign vel_we     = held_we && cmd.upd_set;
  assign q_pop      = (state == ST_FETCH) && !q_empty;
  assign panic_last = (panic_idx == PW'(mnar_pkg::PANIC_RESULTS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_FETCH;
      m_tvalid   <= 1'b0;
      panic_idx  <= '0;
      held_valid <= '0;
      vel_valid  <= '0;
      for (int c = 0; c < CC; c++) begin
        chan_count[c] <= '0;
      end
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_FETCH: begin
          if (!q_empty) begin
            cmd       <= q_head;
            panic_idx <= '0;
            state     <= q_head.panic ? ST_PANIC : ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            if (cmd.upd) begin
              held_valid[cmd.note] <= 1'b1;
              if (cmd.upd_set) begin
                vel_valid[cmd.note] <= 1'b1;
              end
            end
            for (int c = 0; c < CC; c++) begin
              chan_count[c] <= chan_count_next[c];
            end
            m_tlast  <= 1'b1;
            m_tdata  <= {4'd0, active_mask, vel_rep, held_rep[mnar_pkg::PERC_CHANNEL],
                         |held_rep, cmd.count, cmd.second, cmd.first, cmd.status,
                         cmd.to_synth, cmd.send_usb, cmd.send_hw};
            state    <= ST_FETCH;
          end
        end
        ST_PANIC: begin
          if (out_free) begin
            // tracker masks and counts drop at once, velocities are kept
            held_valid <= '0;
            for (int c = 0; c < CC; c++) begin
              chan_count[c] <= '0;
            end
            m_tlast   <= panic_last;
            m_tdata   <= {4'd0, {CC{1'b0}}, vel_query, 1'b0, 1'b0, mnar_pkg::COUNT_TWO,
                          7'd0,
                          panic_idx[0] ? mnar_pkg::CC_NOTES_OFF : mnar_pkg::CC_SOUND_OFF,
                          mnar_pkg::TYPE_CC, panic_idx[PW-1:1],
                          (panic_idx == '0), cmd.send_usb, cmd.send_hw};
            panic_idx <= panic_idx + 1'b1;
            if (panic_last) begin
              state <= ST_FETCH;
            end
          end
        end
        default: state <= ST_FETCH;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/midi_note_activity_router.sv
// midi note-activity router. each input item is one midi channel-voice message with a
// function code: local play goes to the ports in out_target (and to the synth for note
// on/off and program change when audio_out is set), a received message is echoed by
// thru_mode and its source port, an activity item only updates the note tracker, and a
// panic emits cc120 and cc123 for all 16 channels (32 items, synth notice on the first),
// clearing the held-note masks but not the stored velocities. every result item also
// reports the tracker status of query_note after this item's update. an ordinary item
// in the back end has its note tables read in the fetch state, then in the exec state
// updates the tables and loads the output register once that register is free; a panic
// is read alike, then feeds its results through the output register in turn. a small
// queue sits between input classification and the back end, so up to QUEUE_DEPTH input
// items (4 by default) are still accepted while a panic drains or m_tready is low. the
// tracker needs no clearing pass: a valid bit per note stands in for the cleared table.
`default_nettype none

module midi_note_activity_router #(
  parameter int QUEUE_DEPTH = mnar_pkg::QUEUE_DEPTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration, registers at 0x0 out_target, 0x4 thru_mode, 0x8 audio_out
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [mnar_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [mnar_pkg::APB_W-1:0]       pwdata,
  output logic      [mnar_pkg::APB_W-1:0]       prdata,
  output logic                                  pready,
  // input items
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // status[7:0], data1[14:8], data2[21:15], query_note[28:22], zero[31:29]
  input  wire logic [mnar_pkg::IN_DATA_W-1:0]   s_tdata,
  // func[1:0], from_hardware[2]
  input  wire logic [mnar_pkg::IN_USER_W-1:0]   s_tuser,
  // result items
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // send_hw[0], send_usb[1], to_synth[2], out_status[10:3], out_first[17:11],
  // out_second[24:18], out_count[26:25], note_active[27], note_percussion[28],
  // note_velocity[35:29], active_channels[51:36], zero[55:52]
  output logic      [mnar_pkg::OUT_DATA_W-1:0]  m_tdata,
  // last result of the item
  output logic                                  m_tlast
);

  mnar_pkg::cmd_t push_data;
  mnar_pkg::cmd_t head;
  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_empty;

  assign pready = 1'b1;

  // front: config registers and classification of each item
  mnar_front u_front (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (push_data)
  );

  // classified items waiting for the back end
  mnar_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (head)
  );

  // back: note tracker and result generation
  mnar_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire
